FILE: src/at_response_line_parser_defines.svh
// assertion macros shared by the at response line parser rtl
`ifndef AT_RESPONSE_LINE_PARSER_DEFINES_SVH
`define AT_RESPONSE_LINE_PARSER_DEFINES_SVH

// same-cycle implication, checked on every rising clock edge out of reset
`define ATRLP_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("at response line parser assertion failed");

// next-cycle implication, checked on every rising clock edge out of reset
`define ATRLP_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("at response line parser assertion failed");

`endif

FILE: src/atrlp_pkg.sv
// constants and codes for the at response line parser
package atrlp_pkg;

    // line store capacity in bytes and the cursor width that can hold it
    localparam int LINE_CAPACITY = 256;
    localparam int CURSOR_W      = $clog2(LINE_CAPACITY + 1);

    localparam int RAW_LEN_W     = 16;
    localparam int BYTE_W        = 8;
    localparam int S_TDATA_W     = 24;
    localparam int M_TDATA_W     = 48;

    // item kinds carried on the input tuser bit
    localparam logic CMD_BYTE = 1'b0;
    localparam logic CMD_ARM  = 1'b1;

    // characters the parser reacts to
    localparam logic [7:0] CH_CR = 8'h0D;
    localparam logic [7:0] CH_LF = 8'h0A;
    localparam logic [7:0] CH_GT = 8'h3E;

endpackage

FILE: src/at_response_line_parser.sv
// at response line parser: deframes a modem byte stream into lines, prompts and raw blocks
//
// input channel (s_axis): one item per received byte or per arm command.
//   tuser selects the kind: 0 = received byte in tdata[7:0], 1 = arm a raw
//   block whose length is in tdata[23:8]. the raw block starts with the first
//   byte after the next cr lf.
// output channel (m_axis): exactly one result item per input item, in order.
//   tdata carries stored flag, stored byte, position, line length, raw done,
//   raw block length, prompt flag and overflow; tlast marks the item whose
//   cr lf completed a line.
// output: the result sits in an output register the cycle after the input
//   item is accepted.
// throughput: one item per cycle while the receiver does not stall; the whole
//   state transition and cursor and counter update is one pass of logic ahead of the output register.
// stall: ready follows the output register, so while a result waits on a
//   stalled receiver no new item is taken; when the receiver takes the
//   result a new item is accepted in the same cycle.
// reset: synchronous active low; parser returns to idle with cursor, raw
//   remaining count and armed length at zero and no result pending.
`include "at_response_line_parser_defines.svh"

module at_response_line_parser (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_s_axis_tvalid,
    output logic                            o_s_axis_tready,
    // [7:0] rx_byte, [23:8] raw_length
    input  logic [atrlp_pkg::S_TDATA_W-1:0] i_s_axis_tdata,
    // [0] command
    input  logic                            i_s_axis_tuser,
    output logic                            o_m_axis_tvalid,
    input  logic                            i_m_axis_tready,
    // [0] stored, [8:1] stored_byte, [16:9] position, [25:17] line_length,
    // [26] raw_done, [42:27] raw_block_length, [43] prompt_seen,
    // [44] overflow, [47:45] zero
    output logic [atrlp_pkg::M_TDATA_W-1:0] o_m_axis_tdata,
    // line_done
    output logic                            o_m_axis_tlast
);

    import atrlp_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_IDLE_CR,
        ST_RESULT_LF,
        ST_RESULT,
        ST_RAWDATA,
        ST_PROMPT
    } t_state;

    // parser state
    t_state                r_state, n_state;
    logic [CURSOR_W-1:0]   r_cursor, n_cursor;
    logic [RAW_LEN_W-1:0]  r_raw_rem, n_raw_rem;
    logic [RAW_LEN_W-1:0]  r_raw_armed, n_raw_armed;

    // output register
    logic                  r_valid;
    logic                  r_stored, n_stored;
    logic [BYTE_W-1:0]     r_byte, n_byte;
    logic [7:0]            r_pos, n_pos;
    logic                  r_line_done, n_line_done;
    logic [8:0]            r_line_len, n_line_len;
    logic                  r_raw_done, n_raw_done;
    logic [RAW_LEN_W-1:0]  r_raw_len, n_raw_len;
    logic                  r_prompt, n_prompt;
    logic                  r_overflow, n_overflow;

    logic                  accept;
    logic [BYTE_W-1:0]     in_byte;
    logic [RAW_LEN_W-1:0]  in_raw_len;

    // per-byte decode
    logic                  clr_cursor;
    logic                  do_append;
    logic [CURSOR_W-1:0]   cur;
    t_state                ls_state;
    logic                  ls_append;

    assign in_byte    = i_s_axis_tdata[BYTE_W-1:0];
    assign in_raw_len = i_s_axis_tdata[BYTE_W +: RAW_LEN_W];

    // take a new item whenever the output register is empty or being drained
    assign o_s_axis_tready = !r_valid || i_m_axis_tready;
    assign accept          = i_s_axis_tvalid && o_s_axis_tready;

    // start of a line: cr waits for lf, '>' is a prompt, anything else is stored
    always_comb begin
        if (in_byte == CH_CR) begin
            ls_state  = ST_IDLE_CR;
            ls_append = 1'b0;
        end else if (in_byte == CH_GT) begin
            ls_state  = ST_PROMPT;
            ls_append = 1'b0;
        end else begin
            ls_state  = ST_RESULT;
            ls_append = 1'b1;
        end
    end

    always_comb begin
        n_state     = r_state;
        n_raw_rem   = r_raw_rem;
        n_raw_armed = r_raw_armed;
        clr_cursor  = 1'b0;
        do_append   = 1'b0;
        n_cursor    = r_cursor;
        cur         = r_cursor;
        n_stored    = 1'b0;
        n_byte      = '0;
        n_pos       = '0;
        n_line_done = 1'b0;
        n_line_len  = '0;
        n_raw_done  = 1'b0;
        n_raw_len   = '0;
        n_prompt    = 1'b0;
        n_overflow  = 1'b0;

        if (i_s_axis_tuser == CMD_ARM) begin
            // arm answers with an all-zero result
            n_raw_rem   = in_raw_len;
            n_raw_armed = in_raw_len;
        end else begin
            case (r_state)
                ST_IDLE_CR: begin
                    if (in_byte == CH_LF) begin
                        n_state = ST_RESULT_LF;
                    end else if (in_byte != CH_CR) begin
                        n_state = ST_RESULT;
                    end
                end
                ST_RESULT_LF: begin
                    clr_cursor = 1'b1;
                    if (r_raw_rem != '0) begin
                        do_append = 1'b1;
                        n_raw_rem = r_raw_rem - 1'b1;
                        n_state   = ST_RAWDATA;
                    end else begin
                        n_state   = ls_state;
                        do_append = ls_append;
                    end
                end
                ST_RESULT: begin
                    if (in_byte == CH_CR) begin
                        n_state = ST_IDLE_CR;
                    end else begin
                        do_append = 1'b1;
                    end
                end
                ST_RAWDATA: begin
                    if (r_raw_rem == '0) begin
                        // block finished, this byte opens a new line
                        clr_cursor = 1'b1;
                        n_state    = ls_state;
                        do_append  = ls_append;
                    end else begin
                        do_append = 1'b1;
                        n_raw_rem = r_raw_rem - 1'b1;
                    end
                end
                ST_PROMPT: begin
                    clr_cursor = 1'b1;
                    if (in_byte == CH_CR) begin
                        n_state = ST_IDLE_CR;
                    end else begin
                        n_state   = ST_RESULT;
                        do_append = 1'b1;
                    end
                end
                default: begin
                    // idle and unused codes: cursor is kept
                    n_state   = ls_state;
                    do_append = ls_append;
                end
            endcase

            cur      = clr_cursor ? '0 : r_cursor;
            n_cursor = cur;
            if (do_append) begin
                if (cur < CURSOR_W'(LINE_CAPACITY)) begin
                    n_stored = 1'b1;
                    n_byte   = in_byte;
                    n_pos    = 8'(cur);
                    n_cursor = cur + 1'b1;
                end else begin
                    n_overflow = 1'b1;
                end
            end

            if (n_state == ST_RESULT_LF) begin
                n_line_done = 1'b1;
                n_line_len  = 9'(n_cursor);
            end
            // raw done fires once per armed block
            if (n_state == ST_RAWDATA && n_raw_rem == '0 && r_raw_armed != '0) begin
                n_raw_done  = 1'b1;
                n_raw_len   = r_raw_armed;
                n_raw_armed = '0;
            end
            n_prompt = (n_state == ST_PROMPT);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_cursor    <= '0;
            r_raw_rem   <= '0;
            r_raw_armed <= '0;
            r_valid     <= 1'b0;
        end else begin
            if (accept) begin
                r_state     <= n_state;
                r_cursor    <= n_cursor;
                r_raw_rem   <= n_raw_rem;
                r_raw_armed <= n_raw_armed;
                r_valid     <= 1'b1;
                r_stored    <= n_stored;
                r_byte      <= n_byte;
                r_pos       <= n_pos;
                r_line_done <= n_line_done;
                r_line_len  <= n_line_len;
                r_raw_done  <= n_raw_done;
                r_raw_len   <= n_raw_len;
                r_prompt    <= n_prompt;
                r_overflow  <= n_overflow;
            end else if (i_m_axis_tready) begin
                r_valid <= 1'b0;
            end
        end
    end

    assign o_m_axis_tvalid = r_valid;
    assign o_m_axis_tlast  = r_line_done;
    assign o_m_axis_tdata  = {3'b000, r_overflow, r_prompt, r_raw_len, r_raw_done,
                              r_line_len, r_pos, r_byte, r_stored};

    // cursor never runs past the line store
    `ATRLP_ASSERT_IMPL(a_cursor_bound, 1'b1, r_cursor <= CURSOR_W'(LINE_CAPACITY))
    // a byte is either stored or dropped, never both
    `ATRLP_ASSERT_IMPL(a_store_or_drop, r_valid, !(r_stored && r_overflow))
    // a completed raw block leaves nothing counted and nothing armed
    `ATRLP_ASSERT_IMPL(a_raw_done_clear, r_valid && r_raw_done,
        r_raw_rem == '0 && r_raw_armed == '0 && r_state == ST_RAWDATA)
    // line completion and prompt flags agree with the held state
    `ATRLP_ASSERT_IMPL(a_line_done_state, r_valid && r_line_done, r_state == ST_RESULT_LF)
    `ATRLP_ASSERT_IMPL(a_prompt_state, r_valid && r_prompt, r_state == ST_PROMPT)
    // a stalled result keeps the parser state frozen
    `ATRLP_ASSERT_NEXT(a_stall_holds_state, r_valid && !i_m_axis_tready,
        $stable(r_state) && $stable(r_cursor) && $stable(r_raw_rem))

endmodule
